// ===== rtl/core/knxde_pkg.sv =====
// Shared types, type codes and limits for the KNX datapoint encoder.
`timescale 1ns / 1ps

package knxde_pkg;

   // Datapoint type codes; codes above DPT_FLOAT32 are unknown.
   typedef enum logic [3:0] {
      DPT_BOOL    = 4'd0,
      DPT_CVALUE  = 4'd1,
      DPT_CSTEP   = 4'd2,
      DPT_CHAR    = 4'd3,
      DPT_U8      = 4'd4,
      DPT_S8      = 4'd5,
      DPT_U16     = 4'd6,
      DPT_S16     = 4'd7,
      DPT_FLOAT16 = 4'd8,
      DPT_TIME    = 4'd9,
      DPT_DATE    = 4'd10,
      DPT_U32     = 4'd11,
      DPT_S32     = 4'd12,
      DPT_FLOAT32 = 4'd13
   } dpt_code_type;

   localparam int MAG_W = 27;                 // holds the clamped magnitude 2^26
   localparam int EXP_W = 4;
   localparam int EXP_MAX = 15;
   localparam logic [31:0] F16_POS_LIMIT = 32'd67076096;
   localparam logic [31:0] F16_NEG_LIMIT = 32'd67108864;
   localparam logic [11:0] MANT_POS_MAX = 12'd2047;
   localparam logic [11:0] MANT_NEG_MAX = 12'd2048;

   localparam logic [2:0] LEN_NONE  = 3'd0;
   localparam logic [2:0] LEN_ONE   = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   typedef struct packed {
      logic [3:0]         dpt_type;
      logic [1:0]         apci_bits;
      logic               control_bit;
      logic [2:0]         small_value;
      logic [31:0]        raw_value;
      logic signed [31:0] hundredths;
      logic [7:0]         day_field;
      logic [7:0]         hour_or_month;
      logic [7:0]         minute_or_year;
      logic [7:0]         second_value;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [7:0] first_byte;
      logic [7:0] byte_one;
      logic [7:0] byte_two;
      logic [7:0] byte_three;
      logic [7:0] byte_four;
      logic [2:0] payload_length;
   } rsp_type;

   // Stage 1 -> 2: result bytes for every type but float16, plus clamped float.
   typedef struct packed {
      rsp_type            rsp;
      logic               is_float;
      logic               neg;
      logic [MAG_W-1:0]   mag;
   } front_type;

   // Stage 2 -> 3: adds the float16 exponent.
   typedef struct packed {
      front_type          fr;
      logic [EXP_W-1:0]   expo;
   } norm_type;

endpackage

// ===== rtl/core/knx_datapoint_encoder.sv =====
// Top level of the KNX datapoint encoder: three-stage packing pipeline.
`timescale 1ns / 1ps

// Channel   Ports                                   Moves
// req       req_valid, req_ready, req_data          one typed value per transfer
// rsp       rsp_valid, rsp_ready, rsp_data          one packed telegram payload
//
// A req transfer passes the front, norm and pack registers in that order before rsp_valid
// rises. One item enters per cycle while rsp is not stalled.
// Stage 1 decodes and clamps, stage 2 finds the float16 exponent, stage 3 shifts it.
// Each stage holds its own valid bit; a stage advances whenever the next one is
// empty or moving, so bubbles close up and a stall on rsp loses or repeats nothing.
// Synchronous reset clears the valid bits only; payload registers are not reset.

module knx_datapoint_encoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  knxde_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output knxde_pkg::rsp_type  rsp_data
);

   logic                  front_valid, front_ready;
   knxde_pkg::front_type  front_data;
   logic                  norm_valid, norm_ready;
   knxde_pkg::norm_type   norm_data;

   // Decode the type and build all bytes that need no normalization.
   knxde_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   // Pick the smallest exponent that brings the magnitude into mantissa range.
   knxde_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (norm_valid),
      .out_ready (norm_ready),
      .out_data  (norm_data)
   );

   // Shift, negate and hold the finished result until the rsp transfer.
   knxde_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_ready  (norm_ready),
      .in_data   (norm_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

// ===== rtl/core/knxde_front.sv =====
// Stage 1: type decode, byte packing, time/date reduction and float16 clamp.
`timescale 1ns / 1ps

module knxde_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  knxde_pkg::req_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output knxde_pkg::front_type out_data
);

   logic                  valid_ff, valid_in;
   knxde_pkg::front_type  data_ff, data_in;
   logic [31:0]           h_bits, mag32, mag_clamped;
   logic                  neg;

   // Remainder of an 8-bit value by a small constant, restoring steps.
   function automatic logic [7:0] mod_small(input logic [7:0] v, input logic [7:0] m);
      logic [12:0] r;
      logic [12:0] d;
      r = {5'd0, v};
      for (int k = 4; k >= 0; k--) begin
         d = {5'd0, m} << k;
         if (r >= d) begin
            r = r - d;
         end
      end
      return r[7:0];
   endfunction

   always_comb begin
      h_bits = in_data.hundredths;
      neg = h_bits[31];
      mag32 = neg ? (~h_bits + 32'd1) : h_bits;
      if (neg) begin
         mag_clamped = (mag32 > knxde_pkg::F16_NEG_LIMIT) ? knxde_pkg::F16_NEG_LIMIT : mag32;
      end else begin
         mag_clamped = (mag32 > knxde_pkg::F16_POS_LIMIT) ? knxde_pkg::F16_POS_LIMIT : mag32;
      end
   end

   always_comb begin
      data_in = '0;
      data_in.neg = neg;
      data_in.mag = mag_clamped[knxde_pkg::MAG_W-1:0];
      data_in.rsp.accepted = 1'b1;
      data_in.rsp.first_byte = {in_data.apci_bits, 6'd0};
      unique case (in_data.dpt_type) inside
         knxde_pkg::DPT_BOOL: begin
            data_in.rsp.first_byte[0] = in_data.small_value[0];
         end
         knxde_pkg::DPT_CVALUE: begin
            data_in.rsp.first_byte[1:0] = {in_data.control_bit, in_data.small_value[0]};
         end
         knxde_pkg::DPT_CSTEP: begin
            data_in.rsp.first_byte[3:0] = {in_data.control_bit, in_data.small_value};
         end
         knxde_pkg::DPT_CHAR, knxde_pkg::DPT_U8, knxde_pkg::DPT_S8: begin
            data_in.rsp.byte_one = in_data.raw_value[7:0];
            data_in.rsp.payload_length = knxde_pkg::LEN_ONE;
         end
         knxde_pkg::DPT_U16, knxde_pkg::DPT_S16: begin
            data_in.rsp.byte_one = in_data.raw_value[15:8];
            data_in.rsp.byte_two = in_data.raw_value[7:0];
            data_in.rsp.payload_length = knxde_pkg::LEN_TWO;
         end
         knxde_pkg::DPT_FLOAT16: begin
            data_in.is_float = 1'b1;
            data_in.rsp.payload_length = knxde_pkg::LEN_TWO;
         end
         knxde_pkg::DPT_TIME: begin
            data_in.rsp.byte_one = {in_data.day_field[2:0],
                                    5'(mod_small(in_data.hour_or_month, 8'd24))};
            data_in.rsp.byte_two = mod_small(in_data.minute_or_year, 8'd60);
            data_in.rsp.byte_three = mod_small(in_data.second_value, 8'd60);
            data_in.rsp.payload_length = knxde_pkg::LEN_THREE;
         end
         knxde_pkg::DPT_DATE: begin
            data_in.rsp.byte_one = {3'd0, in_data.day_field[4:0]};
            data_in.rsp.byte_two = mod_small(in_data.hour_or_month, 8'd13);
            data_in.rsp.byte_three = mod_small(in_data.minute_or_year, 8'd100);
            data_in.rsp.payload_length = knxde_pkg::LEN_THREE;
         end
         knxde_pkg::DPT_U32, knxde_pkg::DPT_S32, knxde_pkg::DPT_FLOAT32: begin
            data_in.rsp.byte_one = in_data.raw_value[31:24];
            data_in.rsp.byte_two = in_data.raw_value[23:16];
            data_in.rsp.byte_three = in_data.raw_value[15:8];
            data_in.rsp.byte_four = in_data.raw_value[7:0];
            data_in.rsp.payload_length = knxde_pkg::LEN_FOUR;
         end
         default: begin
            // unknown code: drop everything
            data_in.rsp = '0;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

// ===== rtl/core/knxde_norm.sv =====
// Stage 2: float16 exponent search over the clamped magnitude.
`timescale 1ns / 1ps

module knxde_norm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  knxde_pkg::front_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output knxde_pkg::norm_type  out_data
);

   logic                            valid_ff, valid_in;
   knxde_pkg::norm_type             data_ff, data_in;
   logic [knxde_pkg::MAG_W-1:0]     lim;
   logic [knxde_pkg::EXP_MAX-1:0]   fits;
   logic [knxde_pkg::EXP_W-1:0]     expo;

   // One independent compare per exponent below EXP_MAX, then take the smallest that fits.
   always_comb begin
      lim = in_data.neg ? knxde_pkg::MAG_W'(knxde_pkg::MANT_NEG_MAX)
                        : knxde_pkg::MAG_W'(knxde_pkg::MANT_POS_MAX);
      for (int e = 0; e < knxde_pkg::EXP_MAX; e++) begin
         fits[e] = in_data.mag <= (lim << e);
      end
      expo = knxde_pkg::EXP_W'(knxde_pkg::EXP_MAX);
      for (int e = knxde_pkg::EXP_MAX - 1; e >= 0; e--) begin
         if (fits[e]) begin
            expo = knxde_pkg::EXP_W'(e);
         end
      end
   end

   always_comb begin
      data_in.fr = in_data;
      data_in.expo = expo;
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

// ===== rtl/core/knxde_pack.sv =====
// Stage 3: float16 mantissa shift and final result register.
`timescale 1ns / 1ps

module knxde_pack (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  knxde_pkg::norm_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output knxde_pkg::rsp_type   out_data
);

   logic                         valid_ff, valid_in;
   knxde_pkg::rsp_type           data_ff, data_in;
   logic [knxde_pkg::MAG_W-1:0]  quot;
   logic [10:0]                  mant;
   logic                         sign;

   always_comb begin
      quot = in_data.fr.mag >> in_data.expo;
      mant = in_data.fr.neg ? (~quot[10:0] + 11'd1) : quot[10:0];
      sign = in_data.fr.neg && (quot != '0);
      data_in = in_data.fr.rsp;
      if (in_data.fr.is_float) begin
         data_in.byte_one = {sign, in_data.expo, mant[10:8]};
         data_in.byte_two = mant[7:0];
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.accepted |-> data_ff.first_byte == 8'd0
                                        && data_ff.payload_length == knxde_pkg::LEN_NONE)
      else $error("unknown type result carries data");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> data_ff.payload_length <= knxde_pkg::LEN_FOUR)
      else $error("payload length out of range");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.payload_length != knxde_pkg::LEN_FOUR |-> data_ff.byte_four == 8'd0)
      else $error("unused payload byte not cleared");

endmodule
